// ===== rtl/rau_pkg.sv =====
// shared types and codes for the rational arithmetic unit
`timescale 1ns / 1ps
package rau_pkg;
	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_MUL = 3'd1,
		CMD_INV = 3'd2,
		CMD_INC = 3'd3,
		CMD_EQ  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_MUL,
		OP_COMBINE,
		OP_GCD_START,
		OP_GCD_STEP,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t  op;
		logic div_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic gcd_done;
		logic div_done;
		logic trivial;
	} dp_stat_t;
endpackage

// ===== rtl/rau_ctrl.sv =====
// sequencer for the rational arithmetic unit
`timescale 1ns / 1ps
module rau_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rau_pkg::dp_stat_t stat,
	output rau_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_COMB, S_GSTART, S_GCD, S_D0START, S_D0, S_D1START, S_D1, S_OUT
	} state_t;
	state_t state_q;

	always_comb begin
		cmd.div_sel = 1'b0;
		case (state_q)
			S_IDLE:    cmd.op = start ? rau_pkg::OP_LOAD : rau_pkg::OP_NONE;
			S_MUL:     cmd.op = rau_pkg::OP_MUL;
			S_COMB:    cmd.op = rau_pkg::OP_COMBINE;
			S_GSTART:  cmd.op = rau_pkg::OP_GCD_START;
			S_GCD:     cmd.op = rau_pkg::OP_GCD_STEP;
			S_D0START: cmd.op = rau_pkg::OP_DIV_START;
			S_D0:      cmd.op = rau_pkg::OP_DIV_STEP;
			S_D1START: begin
				cmd.op = rau_pkg::OP_DIV_START;
				cmd.div_sel = 1'b1;
			end
			S_D1: begin
				cmd.op = rau_pkg::OP_DIV_STEP;
				cmd.div_sel = 1'b1;
			end
			default:   cmd.op = rau_pkg::OP_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE:    if (start) state_q <= S_MUL;
				S_MUL:     state_q <= S_COMB;
				S_COMB:    state_q <= S_GSTART;
				S_GSTART:  begin
					if (stat.trivial) begin
						state_q <= S_IDLE;
						done <= 1'b1;
					end else begin
						state_q <= S_GCD;
					end
				end
				S_GCD:     if (stat.gcd_done) state_q <= S_D0START;
				S_D0START: state_q <= S_D0;
				S_D0:      if (stat.div_done) state_q <= S_D1START;
				S_D1START: state_q <= S_D1;
				S_D1:      if (stat.div_done) state_q <= S_OUT;
				S_OUT: begin
					state_q <= S_IDLE;
					done <= 1'b1;
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/rau_dp.sv =====
// operand registers, multiplier, gcd and divider for the rational arithmetic unit
`timescale 1ns / 1ps
module rau_dp #(
	parameter int MAG_WIDTH = 31
) (
	input  logic              clk,
	input  rau_pkg::dp_cmd_t  cmd,
	input  logic [2:0]        command,
	input  logic              a_sign,
	input  logic [30:0]       a_num,
	input  logic [30:0]       a_den,
	input  logic              b_sign,
	input  logic [30:0]       b_num,
	input  logic [30:0]       b_den,
	output rau_pkg::dp_stat_t stat,
	output logic              res_sign,
	output logic [30:0]       res_num,
	output logic [30:0]       res_den,
	output logic              is_equal,
	output logic              overflow
);
	localparam int W = MAG_WIDTH;
	localparam int WW = 2 * MAG_WIDTH + 1;
	localparam int CW = $clog2(WW + 1);

	logic [2:0]    cmd_q;
	logic          as_q, bs_q;
	logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
	logic [2*W-1:0] p_q, q_q, d_q;
	logic [WW-1:0] n_q, dd_q, ga_q, gb_q, rem_q, quo_q, dvs_q;
	logic          s_q, eq_q;
	logic [CW-1:0] cnt_q;

	logic [W-1:0]  am, adm, bm, bdm;
	logic          az, bz;
	logic [WW-1:0] trial;
	logic [WW-1:0] rsh;

	assign am  = a_num[W-1:0];
	assign adm = a_den[W-1:0];
	assign bm  = b_num[W-1:0];
	assign bdm = b_den[W-1:0];
	assign az = (am == '0) || (adm == '0);
	assign bz = (bm == '0) || (bdm == '0);

	assign rsh = {rem_q[WW-2:0], quo_q[WW-1]};
	assign trial = rsh - dvs_q;

	assign stat.gcd_done = (gb_q == '0) && (cnt_q == '0);
	assign stat.div_done = (cnt_q == '0);
	assign stat.trivial = (n_q == '0) || (dd_q == '0);

	always_ff @(posedge clk) begin
		case (cmd.op)
			rau_pkg::OP_LOAD: begin
				cmd_q <= command;
				as_q <= az ? 1'b1 : a_sign;
				an_q <= az ? '0 : am;
				ad_q <= az ? W'(1) : adm;
				bs_q <= bz ? 1'b1 : b_sign;
				bn_q <= bz ? '0 : bm;
				bd_q <= bz ? W'(1) : bdm;
				if (command == rau_pkg::CMD_INC) begin
					bs_q <= 1'b1;
					bn_q <= W'(1);
					bd_q <= W'(1);
				end
			end
			rau_pkg::OP_MUL: begin
				if (cmd_q == rau_pkg::CMD_MUL) begin
					p_q <= an_q * bn_q;
					q_q <= '0;
				end else begin
					p_q <= an_q * bd_q;
					q_q <= bn_q * ad_q;
				end
				d_q <= ad_q * bd_q;
			end
			rau_pkg::OP_COMBINE: begin
				eq_q <= 1'b0;
				case (cmd_q)
					rau_pkg::CMD_ADD, rau_pkg::CMD_INC: begin
						dd_q <= WW'(d_q);
						if (as_q == bs_q) begin
							n_q <= WW'(p_q) + WW'(q_q);
							s_q <= as_q;
						end else if (p_q >= q_q) begin
							n_q <= WW'(p_q - q_q);
							s_q <= as_q;
						end else begin
							n_q <= WW'(q_q - p_q);
							s_q <= bs_q;
						end
					end
					rau_pkg::CMD_MUL: begin
						n_q <= WW'(p_q);
						dd_q <= WW'(d_q);
						s_q <= (as_q == bs_q);
					end
					rau_pkg::CMD_INV: begin
						n_q <= WW'(ad_q);
						dd_q <= WW'(an_q);
						s_q <= as_q;
					end
					rau_pkg::CMD_EQ: begin
						n_q <= '0;
						dd_q <= WW'(1);
						if (an_q == '0 || bn_q == '0)
							eq_q <= (an_q == '0) && (bn_q == '0);
						else
							eq_q <= (as_q == bs_q) && (p_q == q_q);
					end
					default: begin
						n_q <= '0;
						dd_q <= WW'(1);
					end
				endcase
			end
			rau_pkg::OP_GCD_START: begin
				ga_q <= n_q;
				gb_q <= dd_q;
				cnt_q <= '0;
				res_sign <= 1'b1;
				res_num <= '0;
				res_den <= 31'd1;
				overflow <= 1'b0;
				is_equal <= eq_q;
			end
			rau_pkg::OP_GCD_STEP: begin
				if (cnt_q == '0) begin
					if (gb_q != '0) begin
						dvs_q <= gb_q;
						quo_q <= ga_q;
						rem_q <= '0;
						cnt_q <= CW'(WW);
					end
				end else begin
					if (!trial[WW-1] || rsh[WW-1]) rem_q <= trial;
					else rem_q <= rsh;
					quo_q <= {quo_q[WW-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						ga_q <= gb_q;
						gb_q <= (!trial[WW-1] || rsh[WW-1]) ? trial : rsh;
					end
				end
			end
			rau_pkg::OP_DIV_START: begin
				dvs_q <= ga_q;
				quo_q <= cmd.div_sel ? dd_q : n_q;
				rem_q <= '0;
				cnt_q <= CW'(WW);
			end
			rau_pkg::OP_DIV_STEP: begin
				if (cnt_q != '0) begin
					if (!trial[WW-1] || rsh[WW-1]) begin
						rem_q <= trial;
						quo_q <= {quo_q[WW-2:0], 1'b1};
					end else begin
						rem_q <= rsh;
						quo_q <= {quo_q[WW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
				end else if (!cmd.div_sel) begin
					n_q <= quo_q;
				end else begin
					if ((n_q >> W) != '0 || (quo_q >> W) != '0) begin
						overflow <= 1'b1;
					end else begin
						res_sign <= s_q;
						res_num <= 31'(n_q[W-1:0]);
						res_den <= 31'(quo_q[W-1:0]);
					end
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== rtl/rational_arithmetic_unit_top.sv =====
// Trivial results (zero, equality, unknown command) skip the gcd and divide steps.
// Other items run gcd steps, then divide the numerator and the denominator by the gcd,
// all in the bit-serial remainder and divide loop; busy stays high throughout.
// One item at a time; results are strobed by done for one cycle, no stall.
// arst_n clears the controller asynchronously; datapath registers hold no reset.
`timescale 1ns / 1ps
module rational_arithmetic_unit_top #(
	parameter int MAG_WIDTH = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [2:0]  command,
	input  logic        a_sign,
	input  logic [30:0] a_num,
	input  logic [30:0] a_den,
	input  logic        b_sign,
	input  logic [30:0] b_num,
	input  logic [30:0] b_den,
	output logic        res_sign,
	output logic [30:0] res_num,
	output logic [30:0] res_den,
	output logic        is_equal,
	output logic        overflow
);
	rau_pkg::dp_cmd_t  cmd;
	rau_pkg::dp_stat_t stat;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.cmd(cmd), .busy(busy), .done(done)
	);

	rau_dp #(.MAG_WIDTH(MAG_WIDTH)) u_dp (
		.clk(clk), .cmd(cmd), .command(command),
		.a_sign(a_sign), .a_num(a_num), .a_den(a_den),
		.b_sign(b_sign), .b_num(b_num), .b_den(b_den),
		.stat(stat), .res_sign(res_sign), .res_num(res_num), .res_den(res_den),
		.is_equal(is_equal), .overflow(overflow)
	);

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res_den != 31'd0)) else $error("zero denominator");
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (res_num == 31'd0)) else $error("overflow value");
`endif
endmodule
